[sv/kaq_pkg.sv]
// Shared constants and a key-select helper for the key autorepeat qualifier.
package kaq_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL   = 2'd3;

  localparam logic [7:0]  PRESS_DELAY_RST    = 8'd1;
  localparam logic [15:0] HOLD_THRESHOLD_RST = 16'd130;
  localparam logic [7:0]  START_INTERVAL_RST = 8'd20;
  localparam logic [7:0]  MIN_INTERVAL_RST   = 8'd1;

  localparam logic [2:0] KEY_LEFT   = 3'd0;
  localparam logic [2:0] KEY_DOWN   = 3'd1;
  localparam logic [2:0] KEY_RIGHT  = 3'd2;
  localparam logic [2:0] KEY_ESCAPE = 3'd3;
  localparam logic [2:0] KEY_UP     = 3'd4;
  localparam logic [2:0] KEY_ENTER  = 3'd5;
  localparam logic [2:0] KEY_NONE   = 3'd6;

  // Lowest active-low line wins.
  function automatic logic [2:0] pick_key(input logic [5:0] lines);
    logic [2:0] k;
    k = KEY_NONE;
    if (!lines[5]) k = KEY_ENTER;
    if (!lines[4]) k = KEY_UP;
    if (!lines[3]) k = KEY_ESCAPE;
    if (!lines[2]) k = KEY_RIGHT;
    if (!lines[1]) k = KEY_DOWN;
    if (!lines[0]) k = KEY_LEFT;
    return k;
  endfunction

endpackage

[sv/key_autorepeat_qualifier.sv]
// Typematic key qualifier with accelerating autorepeat and bit-serial modulo.
//
// One input beat per scan tick carries the six active-low key lines; one
// output beat per tick carries event_valid and the selected key code.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Config registers (press delay, hold threshold, start and minimum interval)
// are written through cfg_wr_en/cfg_index/cfg_wdata. The user must write them
// only while the block is idle; the block itself does not enforce this.
//
// Ticks that need no repeat check load the output register at the accepting
// edge. Once the hold count is past both the threshold and the press delay,
// the count is reduced modulo the repeat interval by a restoring remainder
// unit that retires one dividend bit per cycle; the beat is then loaded from
// ST_DONE once the output is free, and the input stays stalled until then.
//
// Reset (synchronous, rst_n low) loads the register defaults, clears the
// hold count, sets the released flag and loads the start interval.
// A stalled output beat holds; the input then stays stalled until the
// pending beat is taken.
module key_autorepeat_qualifier #(
  parameter int COUNT_WIDTH = kaq_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [5:0]                     in_key_lines,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_event_valid,
  output logic [2:0]                     out_key_code,
  input  logic                           cfg_wr_en,
  input  logic [kaq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kaq_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int CNT_W = $clog2(COUNT_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [7:0]             press_delay_r;
  logic [15:0]            hold_thr_r;
  logic [7:0]             start_iv_r;
  logic [7:0]             min_iv_r;
  logic [COUNT_WIDTH-1:0] hold_r, hold_nxt;
  logic                   released_r, released_nxt;
  logic [7:0]             interval_r, interval_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_event_r, out_event_nxt;
  logic [2:0]             out_key_r, out_key_nxt;
  logic [2:0]             key_r, key_nxt;
  logic [COUNT_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [7:0]             rem_r, rem_nxt;
  logic [CNT_W-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic                   fire_r, fire_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic [2:0]             key_in;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic                   over_thr;
  logic                   over_delay;
  logic [7:0]             divisor;
  logic [8:0]             trial;
  logic                   trial_ge;
  logic [7:0]             iv_dec;
  logic [7:0]             iv_short;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_event_valid = out_event_r;
  assign out_key_code    = out_key_r;

  assign key_in     = kaq_pkg::pick_key(in_key_lines);
  assign hold_inc   = (&hold_r) ? hold_r : hold_r + COUNT_WIDTH'(1);
  assign over_thr   = CMP_W'(hold_inc) > CMP_W'(hold_thr_r);
  assign over_delay = CMP_W'(hold_inc) > CMP_W'(press_delay_r);

  // Zero interval divides like one.
  assign divisor  = (interval_r == 8'd0) ? 8'd1 : interval_r;
  assign trial    = {rem_r, dvd_r[COUNT_WIDTH-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  assign iv_dec   = interval_r - 8'd1;
  assign iv_short = (interval_r == 8'd0 || iv_dec < min_iv_r) ? min_iv_r : iv_dec;

  always_comb begin
    state_nxt     = state_r;
    hold_nxt      = hold_r;
    released_nxt  = released_r;
    interval_nxt  = interval_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_event_nxt = out_event_r;
    out_key_nxt   = out_key_r;
    key_nxt       = key_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    fire_nxt      = fire_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt  = key_in;
          hold_nxt = hold_inc;
          if (over_thr) released_nxt = 1'b1;
          priority if (key_in == kaq_pkg::KEY_NONE) begin
            hold_nxt      = '0;
            released_nxt  = 1'b1;
            interval_nxt  = start_iv_r;
            out_valid_nxt = 1'b1;
            out_event_nxt = 1'b0;
            out_key_nxt   = key_in;
          end else if ((released_r || over_thr) && over_delay && over_thr) begin
            // repeat region: need hold count modulo interval
            dvd_nxt     = hold_inc;
            rem_nxt     = '0;
            bit_cnt_nxt = CNT_W'(COUNT_WIDTH - 1);
            state_nxt   = ST_DIV;
          end else if (released_r && over_delay) begin
            released_nxt  = 1'b0;
            out_valid_nxt = 1'b1;
            out_event_nxt = 1'b1;
            out_key_nxt   = key_in;
          end else begin
            out_valid_nxt = 1'b1;
            out_event_nxt = 1'b0;
            out_key_nxt   = key_in;
          end
        end
      end
      ST_DIV: begin
        // remainder stays below the divisor, so it fits in 8 bits
        rem_nxt     = trial_ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
        dvd_nxt     = {dvd_r[COUNT_WIDTH-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
        if (bit_cnt_r == '0) begin
          fire_nxt  = (rem_nxt == 8'd0);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (fire_r) begin
            interval_nxt = iv_short;
            released_nxt = 1'b0;
          end
          out_valid_nxt = 1'b1;
          out_event_nxt = fire_r;
          out_key_nxt   = key_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      press_delay_r <= kaq_pkg::PRESS_DELAY_RST;
      hold_thr_r    <= kaq_pkg::HOLD_THRESHOLD_RST;
      start_iv_r    <= kaq_pkg::START_INTERVAL_RST;
      min_iv_r      <= kaq_pkg::MIN_INTERVAL_RST;
      hold_r        <= '0;
      released_r    <= 1'b1;
      interval_r    <= kaq_pkg::START_INTERVAL_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_r      <= hold_nxt;
      released_r  <= released_nxt;
      interval_r  <= interval_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          kaq_pkg::REG_PRESS_DELAY:    press_delay_r <= cfg_wdata[7:0];
          kaq_pkg::REG_HOLD_THRESHOLD: hold_thr_r    <= cfg_wdata[15:0];
          kaq_pkg::REG_START_INTERVAL: start_iv_r    <= cfg_wdata[7:0];
          kaq_pkg::REG_MIN_INTERVAL:   min_iv_r      <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_event_r <= out_event_nxt;
    out_key_r   <= out_key_nxt;
    key_r       <= key_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    fire_r      <= fire_nxt;
  end

endmodule

[bench/tb_top.sv]
// Testbench for the key autorepeat qualifier: directed table and random hold sequences.
module tb_top;

  localparam int CW = kaq_pkg::COUNT_WIDTH_DEF;
  localparam int RANDOM_TICKS = 1500;

  typedef struct packed {
    logic       ev;
    logic [2:0] code;
  } key_report_t;

  typedef enum logic {ROW_KEY, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    logic [5:0]                     lines;
    logic [kaq_pkg::CFG_IDX_W-1:0]  idx;
    logic [kaq_pkg::CFG_DATA_W-1:0] data;
    bit                             typed;
    key_report_t                    want;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_QUARTER, STALL_MOST} stall_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [5:0]                     in_key_lines = 6'h3F;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_event_valid;
  logic [2:0]                     out_key_code;
  logic                           cfg_wr_en = 1'b0;
  logic [kaq_pkg::CFG_IDX_W-1:0]  cfg_index = kaq_pkg::REG_PRESS_DELAY;
  logic [kaq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the configuration and tick state
  logic [7:0]    qual_press_dly = kaq_pkg::PRESS_DELAY_RST;
  logic [15:0]   qual_threshold = kaq_pkg::HOLD_THRESHOLD_RST;
  logic [7:0]    qual_start_iv  = kaq_pkg::START_INTERVAL_RST;
  logic [7:0]    qual_min_iv    = kaq_pkg::MIN_INTERVAL_RST;
  logic [CW-1:0] qual_hold      = '0;
  logic          qual_released  = 1'b1;
  logic [7:0]    qual_iv        = kaq_pkg::START_INTERVAL_RST;

  key_report_t due_reports[$];
  stim_row_t   dir_rows[$];

  int fails = 0;
  int beats_out = 0;
  int ticks_sent = 0;
  int burst_left = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          hold_left = 0;
  int          next_hold_at = 400;

  key_autorepeat_qualifier DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_key_lines(in_key_lines),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_event_valid(out_event_valid), .out_key_code(out_key_code),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #200000000;
    $display("Some tests failed");
    $finish;
  end

  // One scan tick of the qualifier; updates the predicted state.
  function automatic key_report_t qualify_tick(input logic [5:0] lines);
    key_report_t r;
    logic [2:0]  code;
    int unsigned divisor;
    logic [7:0]  shrunk;
    bit          fire;
    code = kaq_pkg::KEY_NONE;
    for (int i = 5; i >= 0; i--) if (!lines[i]) code = 3'(i);
    r.ev = 1'b0;
    r.code = code;
    if (qual_hold != '1) qual_hold++;
    if (qual_hold > qual_threshold) qual_released = 1'b1;
    if (code == kaq_pkg::KEY_NONE) begin
      qual_released = 1'b1;
      qual_hold = '0;
      qual_iv = qual_start_iv;
    end else if (qual_released && qual_hold > qual_press_dly) begin
      fire = 1'b1;
      if (qual_hold > qual_threshold) begin
        divisor = (qual_iv == 8'd0) ? 1 : qual_iv;
        if (qual_hold % divisor != 0) begin
          fire = 1'b0;
        end else begin
          shrunk = qual_iv - 8'd1;
          // interval of zero or a floor above the next step both land on the floor
          if (qual_iv == 8'd0 || shrunk < qual_min_iv) shrunk = qual_min_iv;
          qual_iv = shrunk;
        end
      end
      if (fire) begin
        qual_released = 1'b0;
        r.ev = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic stim_row_t key_row(input logic [5:0] lines);
    stim_row_t r;
    r.kind = ROW_KEY;
    r.lines = lines;
    r.idx = kaq_pkg::REG_PRESS_DELAY;
    r.data = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t chk_row(input logic [5:0] lines, input logic ev,
                                        input logic [2:0] code);
    stim_row_t r;
    r = key_row(lines);
    r.typed = 1'b1;
    r.want.ev = ev;
    r.want.code = code;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [kaq_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [kaq_pkg::CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = key_row(6'h3F);
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic logic [5:0] pressed_lines();
    logic [5:0] p;
    if ($urandom_range(0, 1) == 1) begin
      p = ~(6'd1 << $urandom_range(0, 5));
    end else begin
      p = 6'($urandom);
      if (p == 6'h3F) p[$urandom_range(0, 5)] = 1'b0;
    end
    return p;
  endfunction

  task automatic send_tick(input logic [5:0] lines, input bit typed, input key_report_t want);
    key_report_t pred;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_key_lines <= lines;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = qualify_tick(lines);
    due_reports.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  // Drain all pending reports, then wait with the input idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [kaq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kaq_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      kaq_pkg::REG_PRESS_DELAY:    qual_press_dly = data[7:0];
      kaq_pkg::REG_HOLD_THRESHOLD: qual_threshold = data;
      kaq_pkg::REG_START_INTERVAL: qual_start_iv = data[7:0];
      kaq_pkg::REG_MIN_INTERVAL:   qual_min_iv = data[7:0];
      default: ;
    endcase
  endtask

  // Upper bytes of the 8-bit registers carry junk that must be dropped.
  task automatic load_setup(input logic [7:0] pd, input logic [15:0] th,
                            input logic [7:0] si, input logic [7:0] mi);
    settle();
    write_reg(kaq_pkg::REG_PRESS_DELAY, {8'($urandom), pd});
    write_reg(kaq_pkg::REG_HOLD_THRESHOLD, th);
    write_reg(kaq_pkg::REG_START_INTERVAL, {8'($urandom), si});
    write_reg(kaq_pkg::REG_MIN_INTERVAL, {8'($urandom), mi});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_setup();
    logic [7:0]  pd, si, mi;
    logic [15:0] th;
    case ($urandom_range(0, 5))
      0: pd = 8'd0;
      1: pd = 8'd255;
      2: pd = 8'd1;
      default: pd = 8'($urandom_range(0, 20));
    endcase
    case ($urandom_range(0, 5))
      0: th = 16'd0;
      1: th = 16'hFFFF;
      2: th = 16'd130;
      default: th = 16'($urandom_range(0, 60));
    endcase
    case ($urandom_range(0, 5))
      0: si = 8'd0;
      1: si = 8'd255;
      2: si = 8'd1;
      default: si = 8'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 5))
      0: mi = 8'd0;
      1: mi = 8'd255;
      2: mi = 8'd1;
      default: mi = 8'($urandom_range(1, 8));
    endcase
    load_setup(pd, th, si, mi);
  endtask

  // Mostly a held key with some chord changes, then a release; sometimes noise.
  task automatic hold_run();
    logic [5:0] base;
    int len, n, r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) send_tick(6'($urandom), 1'b0, '0);
    end else begin
      base = pressed_lines();
      len = (r < 3) ? $urandom_range(1, 300) : $urandom_range(1, 40);
      repeat (len) send_tick(($urandom_range(0, 3) == 0) ? pressed_lines() : base, 1'b0, '0);
      if (r != 9) begin
        n = $urandom_range(1, 3);
        repeat (n) send_tick(6'h3F, 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 96);
    end
    mode_left--;
    // long hold-off so the block backs up into its input
    if (hold_left == 0 && next_hold_at != 0 && beats_out >= next_hold_at) begin
      hold_left = 300;
      next_hold_at = (next_hold_at < 1000) ? next_hold_at + 600 : 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:    out_stall <= 1'b0;
        STALL_HALF:    out_stall <= ($urandom_range(0, 1) == 1);
        STALL_QUARTER: out_stall <= ($urandom_range(0, 3) == 0);
        default:       out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    key_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected beat: ev=%0b key=%0d", $time, out_event_valid, out_key_code);
        fails++;
      end else begin
        want = due_reports.pop_front();
        if (out_event_valid !== want.ev) begin
          $display("%0t: event_valid mismatch: expected %0b, got %0b",
                   $time, want.ev, out_event_valid);
          fails++;
        end
        if (out_key_code !== want.code) begin
          $display("%0t: key_code mismatch: expected %0d, got %0d",
                   $time, want.code, out_key_code);
          fails++;
        end
      end
    end
  end

  initial begin
    bit prev_cfg;
    int rand_start;
    prev_cfg = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: press delay 1, threshold 130
    dir_rows.push_back(chk_row(6'h3F, 1'b0, kaq_pkg::KEY_NONE));
    dir_rows.push_back(chk_row(6'h3E, 1'b0, kaq_pkg::KEY_LEFT));
    dir_rows.push_back(chk_row(6'h3E, 1'b1, kaq_pkg::KEY_LEFT));
    dir_rows.push_back(chk_row(6'h3D, 1'b0, kaq_pkg::KEY_DOWN));
    dir_rows.push_back(chk_row(6'h3F, 1'b0, kaq_pkg::KEY_NONE));
    dir_rows.push_back(chk_row(6'h3B, 1'b0, kaq_pkg::KEY_RIGHT));
    dir_rows.push_back(chk_row(6'h37, 1'b1, kaq_pkg::KEY_ESCAPE));
    dir_rows.push_back(chk_row(6'h2F, 1'b0, kaq_pkg::KEY_UP));
    dir_rows.push_back(chk_row(6'h1F, 1'b0, kaq_pkg::KEY_ENTER));
    dir_rows.push_back(chk_row(6'h00, 1'b0, kaq_pkg::KEY_LEFT));
    dir_rows.push_back(chk_row(6'h20, 1'b0, kaq_pkg::KEY_LEFT));
    dir_rows.push_back(chk_row(6'h3F, 1'b0, kaq_pkg::KEY_NONE));
    // zero repeat interval
    dir_rows.push_back(cfg_row(kaq_pkg::REG_PRESS_DELAY, 16'hFF00));
    dir_rows.push_back(cfg_row(kaq_pkg::REG_HOLD_THRESHOLD, 16'h0000));
    dir_rows.push_back(cfg_row(kaq_pkg::REG_START_INTERVAL, 16'h5A00));
    dir_rows.push_back(cfg_row(kaq_pkg::REG_MIN_INTERVAL, 16'hC300));
    dir_rows.push_back(key_row(6'h3F));
    dir_rows.push_back(key_row(6'h3E));
    dir_rows.push_back(key_row(6'h3E));
    // floor above the current interval
    dir_rows.push_back(cfg_row(kaq_pkg::REG_START_INTERVAL, 16'd3));
    dir_rows.push_back(cfg_row(kaq_pkg::REG_MIN_INTERVAL, 16'd10));
    dir_rows.push_back(key_row(6'h3F));
    repeat (4) dir_rows.push_back(key_row(6'h3E));
    // register maxima
    dir_rows.push_back(cfg_row(kaq_pkg::REG_PRESS_DELAY, 16'h00FF));
    dir_rows.push_back(cfg_row(kaq_pkg::REG_HOLD_THRESHOLD, 16'hFFFF));
    dir_rows.push_back(cfg_row(kaq_pkg::REG_START_INTERVAL, 16'h00FF));
    dir_rows.push_back(cfg_row(kaq_pkg::REG_MIN_INTERVAL, 16'h00FF));
    dir_rows.push_back(key_row(6'h3F));
    dir_rows.push_back(key_row(6'h2A));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        if (!prev_cfg) settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_wr_en <= 1'b0;
        prev_cfg = 1'b0;
        send_tick(dir_rows[i].lines, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    rand_start = ticks_sent;
    while (ticks_sent - rand_start < RANDOM_TICKS) begin
      random_setup();
      while (ticks_sent - rand_start < RANDOM_TICKS && $urandom_range(0, 24) != 0) hold_run();
    end

    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (2 * CW + 8) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
